### rtl/core/pidaw_pkg.sv
// Package for the anti-windup PID core: widths, register indexes, helpers.
`default_nettype none
package pidaw_pkg;
    localparam int DataWidth = 32;
    localparam int FracBits  = 16;
    localparam int GainWidth = DataWidth - 1;
    localparam int ErrWidth  = DataWidth + 1;
    localparam int AccWidth  = 64;
    localparam int MagWidth  = 64;
    localparam int CntWidth  = 7;

    localparam logic [2:0] RegSetpoint = 3'd0;
    localparam logic [2:0] RegGainP    = 3'd1;
    localparam logic [2:0] RegGainI    = 3'd2;
    localparam logic [2:0] RegGainD    = 3'd3;
    localparam logic [2:0] RegCmdLow   = 3'd4;
    localparam logic [2:0] RegCmdHigh  = 3'd5;
    localparam logic [2:0] RegReverse  = 3'd6;

    localparam logic signed [AccWidth-1:0] SatMax = {1'b0, {(AccWidth-1){1'b1}}};
    localparam logic signed [AccWidth-1:0] SatMin = -SatMax;

    // Saturating add at +-(2^63-1).
    function automatic logic signed [AccWidth-1:0] add_sat(
        input logic signed [AccWidth-1:0] a, input logic signed [AccWidth-1:0] b);
        logic signed [AccWidth:0] s;
        s = {a[AccWidth-1], a} + {b[AccWidth-1], b};
        if (s > $signed({SatMax[AccWidth-1], SatMax}))
            return SatMax;
        if (s < $signed({SatMin[AccWidth-1], SatMin}))
            return SatMin;
        return s[AccWidth-1:0];
    endfunction
endpackage
`default_nettype wire

### rtl/core/pidaw_serial_unit.sv
// Bit-serial shift-add multiplier and restoring divider with Q-format scaling.
`default_nettype none
module pidaw_serial_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic                            div_mode,
    input  wire logic signed [pidaw_pkg::AccWidth-1:0] op_a,
    input  wire logic [pidaw_pkg::MagWidth-1:0]  op_b,
    output logic                                 done,
    output logic signed [pidaw_pkg::AccWidth-1:0] result
);
    import pidaw_pkg::*;

    localparam int MulSteps = MagWidth;
    localparam int DivSteps = MagWidth + FracBits;

    logic                      busy_reg;
    logic [CntWidth:0]         cnt_reg;
    logic                      mode_reg;
    logic                      neg_reg;
    logic [MagWidth-1:0]       mag_reg;   // multiplicand / dividend bits
    logic [MagWidth-1:0]       b_reg;     // multiplier bits / divisor
    logic [2*MagWidth-1:0]     acc_reg;   // product or {rem, quotient}
    logic                      sat_reg;
    logic                      done_reg;

    logic [MagWidth-1:0] a_mag;
    logic [MagWidth:0]   rem_sh;
    logic [MagWidth:0]   mul_sum;
    logic [MagWidth-1:0] q_cur;
    logic [2*MagWidth-1:0] prod_sh;
    logic [MagWidth-1:0] mag_out;
    logic signed [AccWidth-1:0] res_pos;

    assign a_mag = op_a[AccWidth-1] ? MagWidth'(-op_a) : MagWidth'(op_a);
    assign q_cur = acc_reg[MagWidth-1:0];
    assign rem_sh = {acc_reg[2*MagWidth-1:MagWidth], mag_reg[MagWidth-1]};
    assign mul_sum = {1'b0, acc_reg[2*MagWidth-1:MagWidth]} +
                     (b_reg[0] ? {1'b0, mag_reg} : {(MagWidth+1){1'b0}});

    // Step one bit per cycle: multiply scans b LSB first, divide shifts dividend MSB first.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                mode_reg <= div_mode;
                neg_reg  <= op_a[AccWidth-1];
                mag_reg  <= a_mag;
                b_reg    <= op_b;
                acc_reg  <= '0;
                sat_reg  <= 1'b0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (!mode_reg)
                begin
                    // Add the multiplicand into the upper half, shift the product right
                    acc_reg <= {mul_sum, acc_reg[MagWidth-1:1]};
                    b_reg   <= {1'b0, b_reg[MagWidth-1:1]};
                    if (cnt_reg == (CntWidth+1)'(MulSteps - 1))
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
                else
                begin
                    mag_reg <= {mag_reg[MagWidth-2:0], 1'b0};
                    if (q_cur[MagWidth-2])
                        sat_reg <= 1'b1;
                    if (rem_sh >= {1'b0, b_reg})
                        acc_reg <= {MagWidth'(rem_sh - {1'b0, b_reg}),
                                    1'b0, q_cur[MagWidth-3:0], 1'b1};
                    else
                        acc_reg <= {rem_sh[MagWidth-1:0], 1'b0, q_cur[MagWidth-3:0], 1'b0};
                    if (cnt_reg == (CntWidth+1)'(DivSteps - 1))
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // Scale and saturate the finished magnitude, then apply the sign.
    always_comb
    begin
        prod_sh = acc_reg >> FracBits;
        if (mode_reg)
            mag_out = sat_reg ? MagWidth'(SatMax) : q_cur;
        else if (prod_sh[2*MagWidth-1:MagWidth-1] != '0)
            mag_out = MagWidth'(SatMax);
        else
            mag_out = prod_sh[MagWidth-1:0];
        res_pos = AccWidth'(mag_out);
        result  = neg_reg ? -res_pos : res_pos;
    end

    assign done = done_reg;
endmodule
`default_nettype wire

### rtl/core/pid_antiwindup_controller_core.sv
// Top level of the PID controller with conditional-integration anti-windup.
// Usage: write registers on cfg (wr_en, wr_index, wr_data) while idle.
// s_axis carries one sample item: tdata = measurement[31:0], interval[62:32].
// m_axis returns one result item: tdata = command[31:0], tuser = status.
// A zero interval answers with the held command, status 1, valid in the cycle
// after acceptance. A normal item runs a sequence on one shared bit-serial
// unit: a divide for the derivative (80 steps), then multiplies of 64 steps
// each: error times interval, P, D, I on the candidate, and I on the old
// integral when the wind-up test fires. The first item with a nonzero
// interval after reset has no divide. The result is registered from ST_FIN;
// the next item is accepted once the state has passed ST_OUT back to ST_IDLE
// and the result has been taken. One item is in flight at a time.
// s_axis_tready falls while an item is in work or its result waits; the
// result register holds while m_axis_tready is low.
// Reset clears the registers, the integral, the prior error and the held
// command, and leaves no result pending.
`default_nettype none
module pid_antiwindup_controller_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire logic [2:0]  wr_index,
    input  wire logic [31:0] wr_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // measurement[31:0], interval[62:32]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // command[31:0]
    output logic             m_axis_tuser    // status
);
    import pidaw_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_DIV   = 9'b000000010,
        ST_MINT  = 9'b000000100,
        ST_MP    = 9'b000001000,
        ST_MD    = 9'b000010000,
        ST_MI    = 9'b000100000,
        ST_MI2   = 9'b001000000,
        ST_FIN   = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic signed [DataWidth-1:0] setpoint_reg, cmd_low_reg, cmd_high_reg;
    logic [GainWidth-1:0]        gain_p_reg, gain_i_reg, gain_d_reg;
    logic                        reverse_reg;

    logic signed [AccWidth-1:0]  integral_reg;
    logic signed [ErrWidth-1:0]  prior_err_reg;
    logic                        prior_valid_reg;
    logic signed [DataWidth-1:0] held_cmd_reg;

    logic signed [ErrWidth-1:0]  err_reg;
    logic [GainWidth-1:0]        dt_reg;
    logic signed [AccWidth-1:0]  deriv_reg, cand_reg, p_reg, d_reg, cmd_reg;

    logic                        out_valid_reg;
    logic [DataWidth-1:0]        out_cmd_reg;
    logic                        out_status_reg;

    logic                        su_start;
    logic                        su_div;
    logic signed [AccWidth-1:0]  su_a;
    logic [MagWidth-1:0]         su_b;
    logic                        su_done;
    logic signed [AccWidth-1:0]  su_res;

    logic                        div_kick_reg;
    logic                        su_start_any;
    logic signed [AccWidth-1:0]  su_a_any;
    logic [MagWidth-1:0]         su_b_any;
    logic                        su_div_any;

    logic                        in_acc;
    logic signed [DataWidth-1:0] in_meas;
    logic [GainWidth-1:0]        in_dt;
    logic signed [ErrWidth-1:0]  in_err;
    logic signed [ErrWidth:0]    diff;
    logic signed [AccWidth-1:0]  cmd_first, cmd_wide;
    logic                        windup;
    logic signed [AccWidth-1:0]  hi_w, lo_w, cmd_clamp;

    assign in_meas = s_axis_tdata[DataWidth-1:0];
    assign in_dt   = s_axis_tdata[DataWidth+GainWidth-1:DataWidth];
    assign s_axis_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign in_err  = reverse_reg ? (ErrWidth'(in_meas) - ErrWidth'(setpoint_reg))
                                 : (ErrWidth'(setpoint_reg) - ErrWidth'(in_meas));
    assign diff    = err_reg - prior_err_reg;
    assign hi_w    = AccWidth'(cmd_high_reg);
    assign lo_w    = AccWidth'(cmd_low_reg);
    assign cmd_first = add_sat(add_sat(p_reg, su_res), d_reg);
    assign windup  = (cmd_first > hi_w && err_reg > 0) ||
                     (cmd_first < lo_w && err_reg < 0);
    assign cmd_wide = cmd_reg;

    always_comb
    begin
        if (cmd_wide > hi_w)
            cmd_clamp = hi_w;
        else if (cmd_wide < lo_w)
            cmd_clamp = lo_w;
        else
            cmd_clamp = cmd_wide;
    end

    pidaw_serial_unit u_serial (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (su_start_any),
        .div_mode(su_div_any),
        .op_a    (su_a_any),
        .op_b    (su_b_any),
        .done    (su_done),
        .result  (su_res)
    );

    // Pick the next operation of the sequence.
    always_comb
    begin
        state_next = state_reg;
        su_start   = 1'b0;
        su_div     = 1'b0;
        su_a       = '0;
        su_b       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && in_dt != '0)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!prior_valid_reg)
                begin
                    state_next = ST_MINT;
                    su_start = 1'b1;
                    su_a = AccWidth'(err_reg);
                    su_b = MagWidth'(dt_reg);
                end
                else
                begin
                    if (su_done)
                    begin
                        state_next = ST_MINT;
                        su_start = 1'b1;
                        su_a = AccWidth'(err_reg);
                        su_b = MagWidth'(dt_reg);
                    end
                end
            end
            ST_MINT:
            begin
                if (su_done)
                begin
                    state_next = ST_MP;
                    su_start = 1'b1;
                    su_a = AccWidth'(err_reg);
                    su_b = MagWidth'(gain_p_reg);
                end
            end
            ST_MP:
            begin
                if (su_done)
                begin
                    state_next = ST_MD;
                    su_start = 1'b1;
                    su_a = deriv_reg;
                    su_b = MagWidth'(gain_d_reg);
                end
            end
            ST_MD:
            begin
                if (su_done)
                begin
                    state_next = ST_MI;
                    su_start = 1'b1;
                    su_a = cand_reg;
                    su_b = MagWidth'(gain_i_reg);
                end
            end
            ST_MI:
            begin
                if (su_done)
                begin
                    if (windup)
                    begin
                        state_next = ST_MI2;
                        su_start = 1'b1;
                        su_a = integral_reg;
                        su_b = MagWidth'(gain_i_reg);
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_MI2:
            begin
                if (su_done)
                    state_next = ST_FIN;
            end
            ST_FIN:  state_next = ST_OUT;
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Register the state, the configuration and the item; set the divide kick together with the work registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            setpoint_reg    <= '0;
            gain_p_reg      <= '0;
            gain_i_reg      <= '0;
            gain_d_reg      <= '0;
            cmd_low_reg     <= '0;
            cmd_high_reg    <= '0;
            reverse_reg     <= 1'b0;
            integral_reg    <= '0;
            prior_err_reg   <= '0;
            prior_valid_reg <= 1'b0;
            held_cmd_reg    <= '0;
            out_valid_reg   <= 1'b0;
            div_kick_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            div_kick_reg <= 1'b0;
            // Take register writes.
            if (wr_en)
            begin
                case (wr_index)
                    RegSetpoint: setpoint_reg <= wr_data;
                    RegGainP:    gain_p_reg   <= wr_data[GainWidth-1:0];
                    RegGainI:    gain_i_reg   <= wr_data[GainWidth-1:0];
                    RegGainD:    gain_d_reg   <= wr_data[GainWidth-1:0];
                    RegCmdLow:   cmd_low_reg  <= wr_data;
                    RegCmdHigh:  cmd_high_reg <= wr_data;
                    RegReverse:  reverse_reg  <= wr_data[0];
                    default:     ;
                endcase
            end
            // Drop the result once taken.
            if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;
            // Capture the item.
            if (in_acc)
            begin
                err_reg   <= in_err;
                dt_reg    <= in_dt;
                deriv_reg <= '0;
                if (in_dt == '0)
                begin
                    out_valid_reg  <= 1'b1;
                    out_cmd_reg    <= held_cmd_reg;
                    out_status_reg <= 1'b1;
                end
                else
                    div_kick_reg <= 1'b1;
            end
            // Collect the serial unit results.
            if (su_done)
            begin
                case (state_reg)
                    ST_DIV:  deriv_reg <= su_res;
                    ST_MINT: cand_reg  <= add_sat(integral_reg, su_res);
                    ST_MP:   p_reg     <= su_res;
                    ST_MD:   d_reg     <= su_res;
                    ST_MI:   cmd_reg   <= cmd_first;
                    ST_MI2:  cmd_reg   <= add_sat(add_sat(p_reg, su_res), d_reg);
                    default: ;
                endcase
                if (state_reg == ST_MI && !windup)
                    integral_reg <= cand_reg;
            end
            // Commit state and present the result.
            if (state_reg == ST_FIN)
            begin
                held_cmd_reg    <= cmd_clamp[DataWidth-1:0];
                prior_err_reg   <= err_reg;
                prior_valid_reg <= 1'b1;
                out_valid_reg   <= 1'b1;
                out_cmd_reg     <= cmd_clamp[DataWidth-1:0];
                out_status_reg  <= 1'b0;
            end
        end
    end

    // The divide is started from a second port of the start logic.
    always_comb
    begin
        su_start_any = su_start;
        su_a_any     = su_a;
        su_b_any     = su_b;
        su_div_any   = su_div;
        if (div_kick_reg && prior_valid_reg)
        begin
            su_start_any = 1'b1;
            su_div_any   = 1'b1;
            su_a_any     = AccWidth'(diff);
            su_b_any     = MagWidth'(dt_reg);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_cmd_reg;
    assign m_axis_tuser  = out_status_reg;

    // Assertions.
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_axis_tready)
        else $error("input accepted while busy");
    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed under stall");
    a_clamp_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && cmd_low_reg <= cmd_high_reg) |->
        (cmd_clamp <= hi_w && cmd_clamp >= lo_w))
        else $error("command outside limits");
endmodule
`default_nettype wire

### tb/sv/pid_antiwindup_controller_core_tb.sv
// Testbench for the anti-windup PID core: stream stimulus, bit-exact predictor, result check.
module pid_antiwindup_controller_core_tb;
    import pidaw_pkg::*;

    localparam longint SatPos = 64'sh7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [31:0] command;
        logic        status;
    } pid_result_t;

    logic        clk;
    logic        rst_n;
    logic        wr_en;
    logic [2:0]  wr_index;
    logic [31:0] wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // measurement[31:0], interval[62:32]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // command[31:0]
    logic        m_axis_tuser;   // status

    // Controller registers and state as the predictor sees them
    longint      setpoint_q, cmd_low_q, cmd_high_q;
    longint      gain_p_q, gain_i_q, gain_d_q;
    logic        reverse_q;
    longint      integral_q, last_err_q, held_cmd_q;
    logic        last_err_ok;

    pid_result_t pending_results[$];
    int          mismatch_count;
    int          sender_idle_pct;
    int          receiver_stall_pct;
    int          stall_hold_cycles;

    pid_antiwindup_controller_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Generate clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Bound the run
    initial
    begin
        #40_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Saturating add at +-(2^63-1)
    function automatic longint sat_add(longint a, longint b);
        if (b > 0 && a > SatPos - b)
            return SatPos;
        if (b < 0 && a < -SatPos - b)
            return -SatPos;
        return a + b;
    endfunction

    // Fixed-point product: truncate toward zero, saturate
    function automatic longint fix_mul(longint a, longint b);
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] prod;
        longint       m;
        ua   = (a < 0) ? -a : a;
        ub   = (b < 0) ? -b : b;
        prod = ({64'd0, ua} * {64'd0, ub}) >> FracBits;
        m    = (prod[127:63] != 0) ? SatPos : longint'(prod[62:0]);
        return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    // Fixed-point quotient: truncate toward zero, saturate
    function automatic longint fix_div(longint num, longint den);
        logic [63:0] mag;
        logic [79:0] quo;
        longint      m;
        mag = (num < 0) ? -num : num;
        quo = {mag, 16'd0} / {16'd0, den};
        m   = (quo[79:63] != 0) ? SatPos : longint'(quo[62:0]);
        return (num < 0) ? -m : m;
    endfunction

    // Advance the controller state by one sample and return its result
    function automatic pid_result_t pid_advance(logic [31:0] meas_raw, logic [30:0] dt_raw);
        pid_result_t r;
        longint      meas, dt, err, deriv, cand, p_term, d_term, cmd;
        meas = longint'($signed(meas_raw));
        dt   = longint'({33'd0, dt_raw});
        if (dt == 0)
        begin
            r.command = held_cmd_q[31:0];
            r.status  = 1'b1;
            return r;
        end
        err    = reverse_q ? meas - setpoint_q : setpoint_q - meas;
        deriv  = last_err_ok ? fix_div(err - last_err_q, dt) : 0;
        cand   = sat_add(integral_q, fix_mul(err, dt));
        p_term = fix_mul(gain_p_q, err);
        d_term = fix_mul(gain_d_q, deriv);
        cmd    = sat_add(sat_add(p_term, fix_mul(gain_i_q, cand)), d_term);
        // Hold the integral when the command winds up past a limit
        if ((cmd > cmd_high_q && err > 0) || (cmd < cmd_low_q && err < 0))
            cmd = sat_add(sat_add(p_term, fix_mul(gain_i_q, integral_q)), d_term);
        else
            integral_q = cand;
        if (cmd > cmd_high_q)
            cmd = cmd_high_q;
        else if (cmd < cmd_low_q)
            cmd = cmd_low_q;
        held_cmd_q  = cmd;
        last_err_q  = err;
        last_err_ok = 1'b1;
        r.command   = cmd[31:0];
        r.status    = 1'b0;
        return r;
    endfunction

    // Drive the receiver side and check each result item
    always @(posedge clk)
    begin
        pid_result_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: command=%h status=%b",
                             m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                want = pending_results.pop_front();
                if (want.command !== m_axis_tdata || want.status !== m_axis_tuser)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: command exp %h got %h, status exp %b got %b",
                                 want.command, m_axis_tdata, want.status, m_axis_tuser);
                end
            end
        end
        if (stall_hold_cycles > 0)
        begin
            stall_hold_cycles <= stall_hold_cycles - 1;
            m_axis_tready     <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Write one register; the block is idle here
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
        @(posedge clk);
        wr_en    <= 1'b0;
        case (idx)
            RegSetpoint: setpoint_q = longint'($signed(value));
            RegGainP:    gain_p_q   = longint'({33'd0, value[30:0]});
            RegGainI:    gain_i_q   = longint'({33'd0, value[30:0]});
            RegGainD:    gain_d_q   = longint'({33'd0, value[30:0]});
            RegCmdLow:   cmd_low_q  = longint'($signed(value));
            RegCmdHigh:  cmd_high_q = longint'($signed(value));
            RegReverse:  reverse_q  = value[0];
            default: ;
        endcase
    endtask

    // Wait until every result is back, then let the block settle
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_all(logic [31:0] sp, logic [31:0] kp, logic [31:0] ki,
                             logic [31:0] kd, logic [31:0] lo, logic [31:0] hi, logic rev);
        drain();
        write_reg(RegSetpoint, sp);
        write_reg(RegGainP, kp);
        write_reg(RegGainI, ki);
        write_reg(RegGainD, kd);
        write_reg(RegCmdLow, lo);
        write_reg(RegCmdHigh, hi);
        write_reg(RegReverse, {31'd0, rev});
    endtask

    // Offer one sample item and record its expected result on acceptance
    task automatic send_sample(logic [31:0] meas, logic [30:0] dt);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, dt, meas};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_results.push_back(pid_advance(meas, dt));
    endtask

    function automatic logic [30:0] rand_interval();
        case ($urandom_range(9))
            0:       return 31'd0;
            1:       return 31'($urandom);
            2:       return 31'($urandom_range(16));
            default: return 31'($urandom_range(32'h0004_0000, 1));
        endcase
    endfunction

    function automatic logic [31:0] rand_gain();
        case ($urandom_range(5))
            0:       return $urandom & 32'h7FFF_FFFF;
            1:       return 32'd0;
            default: return $urandom_range(32'h0004_0000);
        endcase
    endfunction

    // Extremes of fields, zero interval, inverted limits, wind-up in both directions
    task automatic test_directed;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_sample(32'h0001_0000, 31'd0);          // zero interval right after reset
        write_all(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0000_8000,
                  32'hFFF6_0000, 32'h000A_0000, 1'b0);
        send_sample(32'h0000_0000, 31'h0001_0000);
        send_sample(32'h8000_0000, 31'h0000_0001);  // huge positive error, tiny interval
        send_sample(32'h7FFF_FFFF, 31'h7FFF_FFFF);  // huge negative error, huge interval
        send_sample(32'h7FFF_FFFF, 31'd0);
        send_sample(32'h0001_0000, 31'h0000_4000);
        send_sample(32'hFFFF_0000, 31'h0001_0000);
        // Push the command past the top limit repeatedly
        for (int k = 0; k < 4; k++)
            send_sample(32'hFFE0_0000, 31'h0002_0000);
        for (int k = 0; k < 4; k++)
            send_sample(32'h0020_0000, 31'h0002_0000);
        // Reverse acting, inverted limits
        write_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h0005_0000, 32'hFFFB_0000, 1'b1);
        send_sample(32'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_sample(32'h8000_0000, 31'h0000_0001);
        send_sample(32'h0000_0000, 31'h0000_0100);
        send_sample(32'h0000_0000, 31'd0);
        // Widest limits, setpoint at its top
        write_all(32'h7FFF_FFFF, 32'h0001_0000, 32'h0000_1000, 32'h0000_0100,
                  32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_sample(32'h8000_0000, 31'h0000_0001);
        send_sample(32'h7FFF_FFFF, 31'h0000_0001);
        send_sample(32'h0000_0000, 31'h7FFF_FFFF);
    endtask

    // Random samples under one idling and stalling setting with fresh register values
    task automatic test_random(int n, int idle_pct, int stall_pct);
        logic [31:0] lo, hi, base;
        base = $urandom;
        lo   = $urandom;
        hi   = $urandom;
        if ($urandom_range(3) != 0 && $signed(lo) > $signed(hi))
        begin
            lo = lo ^ hi;
            hi = lo ^ hi;
            lo = lo ^ hi;
        end
        write_all(base, rand_gain(), rand_gain(), rand_gain(), lo, hi,
                  1'($urandom_range(1)));
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int k = 0; k < n; k++)
        begin
            // Most samples sit near the setpoint, some anywhere
            if ($urandom_range(3) == 0)
                send_sample($urandom, rand_interval());
            else
                send_sample(base + $signed($urandom_range(32'h0010_0000)) - 32'h0008_0000,
                            rand_interval());
        end
    endtask

    // Hold the receiver off long enough for the input to stall, then pause the sender
    task automatic test_backpressure;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        stall_hold_cycles  = 3000;
        for (int k = 0; k < 6; k++)
            send_sample($urandom, rand_interval());
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        for (int k = 0; k < 6; k++)
            send_sample($urandom, rand_interval());
    endtask

    initial
    begin
        rst_n         = 1'b0;
        wr_en         = 1'b0;
        wr_index      = RegSetpoint;
        wr_data       = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        setpoint_q = 0; gain_p_q = 0; gain_i_q = 0; gain_d_q = 0;
        cmd_low_q = 0; cmd_high_q = 0; reverse_q = 1'b0;
        integral_q = 0; last_err_q = 0; held_cmd_q = 0; last_err_ok = 1'b0;
        mismatch_count     = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        stall_hold_cycles  = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(110, 0, 0);
        test_random(100, 78, 0);
        test_backpressure();
        test_random(100, 0, 78);
        test_random(100, 33, 33);
        drain();
        repeat (500) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

### pid_antiwindup_controller_core.f
rtl/core/pidaw_pkg.sv
rtl/core/pidaw_serial_unit.sv
rtl/core/pid_antiwindup_controller_core.sv
tb/sv/pid_antiwindup_controller_core_tb.sv
